// File: rtl/dds_sine_pwm_tone_with_ramp_defines.svh
// assertion macros for the tone generator checker
// no dependencies
`ifndef DDS_SINE_PWM_TONE_WITH_RAMP_DEFINES_SVH
`define DDS_SINE_PWM_TONE_WITH_RAMP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone generator check failed");

// next-cycle implication, sampled on clk, off during rst
`define DDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone generator check failed");

`endif

// File: rtl/dds_tone_pkg.sv
// shared types, codes, constants and sine table for the tone generator
// no dependencies
package dds_tone_pkg;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_TONE = 2'd1;
  localparam logic [1:0] MODE_SIL  = 2'd2;
  localparam logic [1:0] MODE_STOP = 2'd3;

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_RAMP = 2'd1;
  localparam logic [1:0] H_SINE = 2'd2;

  localparam int RAMP_TICKS = 2048;
  localparam int RAMP_CW    = $clog2(RAMP_TICKS + 1);

  localparam int DIV_NW = 24;
  localparam int DIV_DW = 20;
  localparam int DIV_CW = $clog2(DIV_NW);
  localparam logic [DIV_NW-1:0] PERIOD_NUM = DIV_NW'(1000000);
  localparam int STEP_SHIFT = 14;

  localparam logic [9:0] DUTY_MID = 10'd512;
  localparam logic [9:0] DUTY_MAX = 10'd1023;
  localparam logic [9:0] TP_RESET = 10'd20;

  typedef struct packed {
    logic accept;
    logic sine_out;
    logic div_go;
    logic div_sel;
    logic step_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic go_sine;
    logic go_div;
    logic div_done;
  } ctrl_sts_t;

  function automatic logic [6:0] quarter(input logic [6:0] r);
    logic [6:0] v;
    unique case (r)
      7'd0: v = 7'd0;     7'd1: v = 7'd3;     7'd2: v = 7'd6;     7'd3: v = 7'd9;
      7'd4: v = 7'd12;    7'd5: v = 7'd16;    7'd6: v = 7'd19;    7'd7: v = 7'd22;
      7'd8: v = 7'd25;    7'd9: v = 7'd28;    7'd10: v = 7'd31;   7'd11: v = 7'd34;
      7'd12: v = 7'd37;   7'd13: v = 7'd40;   7'd14: v = 7'd43;   7'd15: v = 7'd46;
      7'd16: v = 7'd49;   7'd17: v = 7'd51;   7'd18: v = 7'd54;   7'd19: v = 7'd57;
      7'd20: v = 7'd60;   7'd21: v = 7'd63;   7'd22: v = 7'd65;   7'd23: v = 7'd68;
      7'd24: v = 7'd71;   7'd25: v = 7'd73;   7'd26: v = 7'd76;   7'd27: v = 7'd78;
      7'd28: v = 7'd81;   7'd29: v = 7'd83;   7'd30: v = 7'd85;   7'd31: v = 7'd88;
      7'd32: v = 7'd90;   7'd33: v = 7'd92;   7'd34: v = 7'd94;   7'd35: v = 7'd96;
      7'd36: v = 7'd98;   7'd37: v = 7'd100;  7'd38: v = 7'd102;  7'd39: v = 7'd104;
      7'd40: v = 7'd106;  7'd41: v = 7'd107;  7'd42: v = 7'd109;  7'd43: v = 7'd111;
      7'd44: v = 7'd112;  7'd45: v = 7'd113;  7'd46: v = 7'd115;  7'd47: v = 7'd116;
      7'd48: v = 7'd117;  7'd49: v = 7'd118;  7'd50: v = 7'd120;  7'd51: v = 7'd121;
      7'd52: v = 7'd122;  7'd53: v = 7'd122;  7'd54: v = 7'd123;  7'd55: v = 7'd124;
      7'd56: v = 7'd125;  7'd57: v = 7'd125;  7'd58: v = 7'd126;  7'd59: v = 7'd126;
      7'd60: v = 7'd126;  7'd61: v = 7'd127;  7'd62: v = 7'd127;  7'd63: v = 7'd127;
      7'd64: v = 7'd127;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] sine_lookup(input logic [7:0] idx);
    logic [6:0] r;
    logic [6:0] v;
    r = {1'b0, idx[5:0]};
    v = idx[6] ? quarter(7'd64 - r) : quarter(r);
    return idx[7] ? -signed'({1'b0, v}) : signed'({1'b0, v});
  endfunction

endpackage

// File: rtl/dds_tone_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on dds_tone_pkg
module dds_tone_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [dds_tone_pkg::DIV_NW-1:0] dividend,
  input  logic [dds_tone_pkg::DIV_DW-1:0] divisor,
  output logic [dds_tone_pkg::DIV_NW-1:0] quo,
  output logic                           done
);
  import dds_tone_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem, quo[DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

// File: rtl/dds_tone_ctrl.sv
// control state machine: input handshake, sine output step, divider sequencing
// depends on dds_tone_pkg
module dds_tone_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  dds_tone_pkg::ctrl_sts_t sts,
  output dds_tone_pkg::ctrl_cmd_t cmd
);
  import dds_tone_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SINE  = 2'd1;
  localparam logic [1:0] ST_DIV_P = 2'd2;
  localparam logic [1:0] ST_DIV_S = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE) && sts.out_free;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.accept    = s_tvalid && s_tready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.go_sine) begin
          state_next = ST_SINE;
        end else if (cmd.accept && sts.go_div) begin
          cmd.div_go = 1'b1;
          state_next = ST_DIV_P;
        end
      end
      ST_SINE: begin
        cmd.sine_out = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_DIV_P: begin
        if (sts.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = 1'b1;
          state_next  = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (sts.div_done) begin
          cmd.step_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/dds_tone_dp.sv
// datapath: tone state, ramp, sine scaling, phase step divider, output register
// depends on dds_tone_pkg and dds_tone_div
module dds_tone_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [9:0]              cfg_wdata,
  input  logic [1:0]              in_mode,
  input  logic                    in_channel,
  input  logic [15:0]             in_freq,
  input  logic [7:0]              in_amp,
  input  logic                    m_tready,
  output logic                    m_tvalid,
  output logic                    m_channel,
  output logic [9:0]              m_duty,
  output logic                    m_on,
  input  dds_tone_pkg::ctrl_cmd_t cmd,
  output dds_tone_pkg::ctrl_sts_t sts
);
  import dds_tone_pkg::*;

  logic [9:0]         tick_period_us;
  logic [9:0]         tp_hold;
  logic [15:0]        phase;
  logic [15:0]        phase_step;
  logic [7:0]         tone_gain;
  logic               active_channel;
  logic [RAMP_CW-1:0] ramp_count;
  logic               ramp_then_sine;
  logic               output_live;
  logic [1:0]         tick_handler;
  logic signed [16:0] prod;

  logic [15:0]        phase_next;
  logic [RAMP_CW-1:0] ramp_inc;
  logic [12:0]        ramp_q;
  logic [9:0]         ramp_duty;
  logic signed [16:0] prod_adj;
  logic signed [10:0] scaled;
  logic [9:0]         sine_duty;

  logic               emit;
  logic               emit_ch;
  logic [9:0]         emit_duty;
  logic               emit_on;

  logic [DIV_NW-1:0]  div_n;
  logic [DIV_DW-1:0]  div_d;
  logic [DIV_NW-1:0]  div_q;
  logic               div_done;

  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.go_sine  = (in_mode == MODE_TICK) && (tick_handler == H_SINE);
  assign sts.go_div   = (in_mode == MODE_TONE) && (in_freq != 16'd0);
  assign sts.div_done = div_done;

  assign phase_next = phase + phase_step;
  assign ramp_inc   = ramp_count + 1'b1;
  assign ramp_q     = 13'(ramp_inc) >> 2;
  assign ramp_duty  = (ramp_q > 13'(DUTY_MAX)) ? DUTY_MAX : ramp_q[9:0];
  assign prod_adj   = prod + (prod[16] ? 17'sd63 : 17'sd0);
  assign scaled     = 11'(prod_adj >>> 6);
  assign sine_duty  = scaled[9:0] + DUTY_MID;

  assign div_n = cmd.div_sel ? DIV_NW'({tp_hold, STEP_SHIFT'(0)}) : PERIOD_NUM;
  assign div_d = cmd.div_sel ? div_q[DIV_DW-1:0] : DIV_DW'(in_freq);

  dds_tone_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .quo      (div_q),
    .done     (div_done)
  );

  always_comb begin
    emit      = 1'b0;
    emit_ch   = in_channel;
    emit_duty = 10'd0;
    emit_on   = 1'b1;
    if (cmd.sine_out) begin
      emit      = 1'b1;
      emit_ch   = active_channel;
      emit_duty = sine_duty;
    end else if (cmd.accept) begin
      unique case (in_mode)
        MODE_TICK: begin
          if (tick_handler == H_RAMP && ramp_inc[1:0] == 2'd0) begin
            emit      = 1'b1;
            emit_ch   = active_channel;
            emit_duty = ramp_duty;
          end
        end
        MODE_TONE: begin
          emit      = in_freq != 16'd0;
          emit_duty = output_live ? DUTY_MID : 10'd0;
        end
        MODE_SIL: begin
          emit      = 1'b1;
          emit_duty = output_live ? DUTY_MID : 10'd0;
        end
        MODE_STOP: begin
          emit    = 1'b1;
          emit_on = 1'b0;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_us <= TP_RESET;
      phase          <= '0;
      phase_step     <= '0;
      tone_gain      <= '0;
      active_channel <= 1'b0;
      ramp_count     <= '0;
      ramp_then_sine <= 1'b0;
      output_live    <= 1'b0;
      tick_handler   <= H_IDLE;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_period_us <= cfg_wdata;
      end
      if (cmd.step_load) begin
        phase_step <= div_q[15:0];
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.accept) begin
        unique case (in_mode)
          MODE_TICK: begin
            if (tick_handler == H_RAMP) begin
              ramp_count <= ramp_inc;
              if (ramp_inc >= RAMP_CW'(RAMP_TICKS)) begin
                tick_handler <= ramp_then_sine ? H_SINE : H_IDLE;
              end
            end else if (tick_handler == H_SINE) begin
              phase <= phase_next;
            end
          end
          MODE_TONE: begin
            if (in_freq != 16'd0) begin
              active_channel <= in_channel;
              tone_gain      <= in_amp;
              phase          <= '0;
              if (output_live) begin
                tick_handler <= H_SINE;
              end else begin
                ramp_count     <= '0;
                ramp_then_sine <= 1'b1;
                tick_handler   <= H_RAMP;
                output_live    <= 1'b1;
              end
            end
          end
          MODE_SIL: begin
            if (output_live) begin
              tick_handler <= H_IDLE;
            end else begin
              active_channel <= in_channel;
              ramp_count     <= '0;
              ramp_then_sine <= 1'b0;
              tick_handler   <= H_RAMP;
              output_live    <= 1'b1;
            end
          end
          MODE_STOP: begin
            output_live  <= 1'b0;
            tick_handler <= H_IDLE;
          end
          default: tick_handler <= tick_handler;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tp_hold <= tick_period_us;
      prod    <= 17'(sine_lookup(phase_next[13:6])) * 17'(signed'({1'b0, tone_gain}));
    end
    if (emit) begin
      m_channel <= emit_ch;
      m_duty    <= emit_duty;
      m_on      <= emit_on;
    end
  end

endmodule

// File: rtl/dds_sine_pwm_tone_with_ramp.sv
// Tone generator: sine synthesis with anti-click ramp, 10-bit PWM duty words.
// Depends on dds_tone_pkg, dds_tone_ctrl, dds_tone_dp, dds_tone_div.
//
// Input channel s_*: one command word per handshake (tick, start tone, silence,
// stop). Output channel m_*: one duty update word, or none, per command.
// cfg_we/cfg_wdata set the tick period in microseconds (reset value 20).
// Ramp ticks, silence, stop and start tone register their word into m_* at the
// accepting edge. A sine tick passes through the product register (phase add,
// table and multiply), then scaling into the output register.
// Idle or ramp ticks, silence and stop can be taken back to back while the
// output register is free; a sine tick holds s_tready low until its word is
// registered, and a start tone with nonzero frequency holds s_tready low while
// the shared radix-2 divider runs its two 24-step divisions for the phase step.
// A new word is taken only while the output register is empty or being read,
// so a stalled receiver holds m_* steady and stops the input side.
// Reset (rst, synchronous) clears the tone state, turns the output off and
// restores the tick period; no clearing pass is needed.
module dds_sine_pwm_tone_with_ramp (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // frequency_hz[15:0], amplitude[23:16]
  input  logic [2:0]  s_tuser,   // mode[1:0], channel[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // duty[9:0], zero[15:10]
  output logic [1:0]  m_tuser    // out_channel[0], pwm_on[1]
);
  import dds_tone_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic       m_channel;
  logic [9:0] m_duty;
  logic       m_on;

  dds_tone_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dds_tone_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (s_tuser[1:0]),
    .in_channel (s_tuser[2]),
    .in_freq    (s_tdata[15:0]),
    .in_amp     (s_tdata[23:16]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_channel  (m_channel),
    .m_duty     (m_duty),
    .m_on       (m_on),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign m_tdata = {6'd0, m_duty};
  assign m_tuser = {m_on, m_channel};

endmodule

// File: rtl/dds_tone_checker.sv
// port-level checks for the tone generator, bound to the top level
// depends on dds_tone_pkg and dds_sine_pwm_tone_with_ramp_defines.svh
`include "dds_sine_pwm_tone_with_ramp_defines.svh"

module dds_tone_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import dds_tone_pkg::*;

  // stalled word holds
  `DDS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // pwm off carries zero duty
  `DDS_ASSERT_NOW(a_off_zero, m_tvalid && !m_tuser[1], m_tdata[9:0] == 10'd0)

  // stop gives an off word on the addressed channel next cycle
  `DDS_ASSERT_NEXT(a_stop, s_tvalid && s_tready && s_tuser[1:0] == MODE_STOP, m_tvalid && !m_tuser[1] && m_tuser[0] == $past(s_tuser[2]))

  // start tone with nonzero frequency blocks input while the step is worked out
  `DDS_ASSERT_NEXT(a_tone_busy, s_tvalid && s_tready && s_tuser[1:0] == MODE_TONE && s_tdata[15:0] != 16'd0, !s_tready)

endmodule

bind dds_sine_pwm_tone_with_ramp dds_tone_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: verif/tb_dds_sine_pwm_tone_with_ramp.sv
// self-checking testbench for the tone generator: drives command words, predicts
// every duty word from its own tone model and compares them field by field
// depends on dds_tone_pkg and dds_sine_pwm_tone_with_ramp
module tb_dds_sine_pwm_tone_with_ramp;
  import dds_tone_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  mode;
    logic        ch;
    logic [15:0] freq;
    logic [7:0]  amp;
  } tone_cmd_t;

  typedef struct packed {
    logic       ch;
    logic [9:0] duty;
    logic       pwm_on;
  } duty_upd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // frequency_hz[15:0], amplitude[23:16]
  logic [2:0]  s_tuser = '0;   // mode[1:0], channel[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // duty[9:0], zero[15:10]
  logic [1:0]  m_tuser;        // out_channel[0], pwm_on[1]

  dds_sine_pwm_tone_with_ramp u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tone model state
  logic [15:0]       tone_phase = '0;
  logic [15:0]       tone_step = '0;
  logic [7:0]        tone_gain = '0;
  logic              act_ch = 1'b0;
  int                ramp_cnt = 0;
  logic              ramp_to_sine = 1'b0;
  logic              out_live = 1'b0;
  logic [1:0]        handler = H_IDLE;
  logic [9:0]        tick_period = TP_RESET;
  logic signed [7:0] sine_tab [256];

  tone_cmd_t cmd_q[$];
  duty_upd_t pending_duty[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int effective_words = 0;
  int words_sent = 0;
  int duty_checked = 0;
  int err_count = 0;
  int stall_cycles = 0;

  task automatic advance_tone(input tone_cmd_t w);
    duty_upd_t   u;
    logic        hit;
    int unsigned period;
    int          s, g, v;
    hit = 1'b0;
    u = '0;
    case (w.mode)
      MODE_TICK: begin
        if (handler == H_RAMP) begin
          effective_words++;
          ramp_cnt = ramp_cnt + 1;
          if (ramp_cnt % 4 == 0) begin
            hit = 1'b1;
            u.ch = act_ch;
            u.duty = (ramp_cnt / 4 > int'(DUTY_MAX)) ? DUTY_MAX : 10'(ramp_cnt / 4);
            u.pwm_on = 1'b1;
          end
          if (ramp_cnt >= RAMP_TICKS) handler = ramp_to_sine ? H_SINE : H_IDLE;
        end else if (handler == H_SINE) begin
          effective_words++;
          tone_phase = tone_phase + tone_step;
          s = sine_tab[tone_phase[13:6]];
          g = tone_gain;
          v = s * g / 64 + 512;
          hit = 1'b1;
          u.ch = act_ch;
          u.duty = v[9:0];
          u.pwm_on = 1'b1;
        end
      end
      MODE_TONE: begin
        if (w.freq != 16'd0) begin
          effective_words++;
          period = 1000000 / w.freq;
          tone_step = 16'((32'd16384 * tick_period) / period);
          act_ch = w.ch;
          tone_gain = w.amp;
          tone_phase = '0;
          hit = 1'b1;
          u.ch = w.ch;
          u.pwm_on = 1'b1;
          if (out_live) begin
            handler = H_SINE;
            u.duty = DUTY_MID;
          end else begin
            ramp_cnt = 0;
            ramp_to_sine = 1'b1;
            handler = H_RAMP;
            out_live = 1'b1;
            u.duty = '0;
          end
        end
      end
      MODE_SIL: begin
        effective_words++;
        hit = 1'b1;
        u.ch = w.ch;
        u.pwm_on = 1'b1;
        if (out_live) begin
          handler = H_IDLE;
          u.duty = DUTY_MID;
        end else begin
          act_ch = w.ch;
          ramp_cnt = 0;
          ramp_to_sine = 1'b0;
          handler = H_RAMP;
          out_live = 1'b1;
          u.duty = '0;
        end
      end
      default: begin
        effective_words++;
        out_live = 1'b0;
        handler = H_IDLE;
        hit = 1'b1;
        u.ch = w.ch;
        u.duty = '0;
        u.pwm_on = 1'b0;
      end
    endcase
    if (hit) pending_duty.push_back(u);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_tone(cmd_q.pop_front());
        words_sent++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {cmd_q[0].amp, cmd_q[0].freq};
        s_tuser <= {cmd_q[0].ch, cmd_q[0].mode};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // duty word monitor
  always @(posedge clk) begin
    duty_upd_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        duty_checked++;
        if (pending_duty.size() == 0) begin
          err_count++;
          $display("%0t: unexpected duty word: expected none, got ch=%0d duty=%0d on=%0d",
                   $time, m_tuser[0], m_tdata[9:0], m_tuser[1]);
        end else begin
          e = pending_duty.pop_front();
          if (m_tuser[0] !== e.ch || m_tdata !== {6'd0, e.duty} || m_tuser[1] !== e.pwm_on) begin
            err_count++;
            $display("%0t: duty word mismatch: expected ch=%0d duty=%0d on=%0d, got ch=%0d tdata=%h on=%0d",
                     $time, e.ch, e.duty, e.pwm_on, m_tuser[0], m_tdata, m_tuser[1]);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] mode, input logic ch, input logic [15:0] freq,
                          input logic [7:0] amp);
    tone_cmd_t w;
    w.mode = mode;
    w.ch = ch;
    w.freq = freq;
    w.amp = amp;
    cmd_q.push_back(w);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(MODE_TICK, 1'($urandom_range(1)), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] rand_freq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 40) return 16'($urandom_range(2000, 1));
    return 16'($urandom_range(65535, 1));
  endfunction

  // waits for every word out and for the phase step divider to finish
  task automatic wait_drained();
    while (cmd_q.size() != 0 || pending_duty.size() != 0 || !s_tready) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_tick_period(input logic [9:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_period = v;
  endtask

  task automatic run_random(input int count);
    int          target;
    int unsigned kind;
    target = effective_words + count;
    while (effective_words < target) begin
      if (cmd_q.size() >= 64) begin
        @(posedge clk);
      end else begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          push_cmd(MODE_TONE, 1'($urandom_range(1)), rand_freq(), 8'($urandom));
          push_ticks($urandom_range(40, 4));
        end else if (kind < 60) begin
          push_cmd(MODE_STOP, 1'($urandom_range(1)), rand_freq(), 8'($urandom));
          push_cmd($urandom_range(1) ? MODE_TONE : MODE_SIL, 1'($urandom_range(1)),
                   rand_freq(), 8'($urandom));
          push_ticks($urandom_range(48, 4));
          push_cmd(MODE_TONE, 1'($urandom_range(1)), rand_freq(), 8'($urandom));
          push_ticks($urandom_range(24, 2));
        end else if (kind < 70) begin
          push_cmd(MODE_SIL, 1'($urandom_range(1)), rand_freq(), 8'($urandom));
          push_ticks($urandom_range(12, 1));
        end else if (kind < 73) begin
          wait_drained();
        end else begin
          repeat ($urandom_range(6, 1))
            push_cmd(2'($urandom_range(3)), 1'($urandom_range(1)), 16'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int qw [65];
    int a;
    for (int k = 0; k <= 64; k++) qw[k] = $rtoi(127.0 * $sin(3.14159265358979 * k / 128.0) + 0.5);
    for (int k = 0; k < 256; k++) begin
      a = ((k / 64) % 2 == 1) ? qw[64 - k % 64] : qw[k % 64];
      sine_tab[k] = (k >= 128) ? 8'(-a) : 8'(a);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, zero frequency, stop, ramp, tone while live, silence both ways
    push_cmd(MODE_TICK, 1'b1, 16'hFFFF, 8'hFF);
    push_cmd(MODE_TONE, 1'b1, 16'd0, 8'hFF);
    push_cmd(MODE_STOP, 1'b1, 16'hFFFF, 8'hFF);
    push_cmd(MODE_TONE, 1'b1, 16'hFFFF, 8'hFF);
    push_ticks(4);
    push_cmd(MODE_TONE, 1'b0, 16'd1, 8'd0);
    push_ticks(1);
    push_cmd(MODE_TONE, 1'b0, 16'd1000, 8'hFF);
    push_ticks(3);
    push_cmd(MODE_SIL, 1'b1, 16'd0, 8'd0);
    push_ticks(1);
    push_cmd(MODE_STOP, 1'b0, 16'd0, 8'd0);
    push_cmd(MODE_SIL, 1'b0, 16'h0000, 8'h00);
    push_ticks(4);
    push_cmd(MODE_TONE, 1'b1, 16'hFFFF, 8'd128);
    push_ticks(2);
    wait_drained();

    set_tick_period(10'd1);
    run_random(180);
    wait_drained();

    set_tick_period(10'd1000);
    send_idle_pct = 83;
    run_random(180);
    wait_drained();

    set_tick_period(10'd0);
    send_idle_pct = 0;
    recv_idle_pct = 83;
    run_random(180);
    wait_drained();

    set_tick_period(10'd1023);
    send_idle_pct = 6;
    recv_idle_pct = 6;
    run_random(180);
    wait_drained();

    set_tick_period(10'($urandom_range(1000, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(180);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d command words and checked %0d duty words over ramps, sine and stops",
             words_sent, duty_checked);
    $display("tick periods 20, 1, 1000, 0, 1023 and one random; idling none, sender, receiver, both");
    if (err_count == 0 && pending_duty.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dds_tone_pkg.sv
rtl/dds_tone_div.sv
rtl/dds_tone_ctrl.sv
rtl/dds_tone_dp.sv
rtl/dds_sine_pwm_tone_with_ramp.sv
rtl/dds_tone_checker.sv
verif/tb_dds_sine_pwm_tone_with_ramp.sv
